>>> design/i2crm_pkg.sv
// Shared types, constants and helpers for the I2C target register map.
`default_nettype none

package i2crm_pkg;

  // Register map geometry
  localparam int NUM_REGS        = 19;
  localparam int RW_FIRST        = 2;
  localparam int RW_LAST         = 18;
  localparam int WRITE_BUF_BYTES = 32;
  localparam int VERSION_VALUE   = 1;

  localparam logic [7:0] BOARD_ID_VALUE = 8'h10;
  localparam int         ID_SLOT        = 0;
  localparam int         VERSION_SLOT   = 1;

  localparam int PTR_W = 5;
  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int CNT_W = $clog2(WRITE_BUF_BYTES + 1);

  // Bus and host event codes
  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_WR_BYTE  = 3'd1,
    CMD_RD_BYTE  = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_HOST_SET = 3'd4,
    CMD_HOST_GET = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [7:0]       data;
    logic [PTR_W-1:0] host_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       value_changed;
  } result_t;

  // Registered event handed from the capture stage to the map core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic logic [7:0] bank_reset_value(input int slot);
    logic [7:0] val;
    val = 8'h00;
    if (slot == ID_SLOT) begin
      val = BOARD_ID_VALUE;
    end else if (slot == VERSION_SLOT) begin
      val = 8'(VERSION_VALUE);
    end
    return val;
  endfunction

endpackage

`default_nettype wire

>>> design/i2crm_in_stage.sv
// Capture register for incoming bus and host events.
`default_nettype none

module i2crm_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire i2crm_pkg::item_t item_i,
  output i2crm_pkg::stage_t    stage_o
);
  import i2crm_pkg::*;

  logic  valid_q;
  item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  // payload: hold only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      item_q <= item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

`default_nettype wire

>>> design/i2crm_core.sv
// Register bank, pointer, write counter and result register.
`default_nettype none

module i2crm_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire i2crm_pkg::stage_t stage_i,
  output logic                   done_o,
  output i2crm_pkg::result_t     result_o
);
  import i2crm_pkg::*;

  logic [7:0]       bank_q [NUM_REGS];
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q;
  result_t          result_q, result_d;

  logic [PTR_W-1:0] rd_sel;
  logic             rd_ok;
  logic [7:0]       rd_val;
  logic [PTR_W:0]   ptr_inc;
  logic [PTR_W-1:0] ptr_next;
  logic             in_window;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_val;
  item_t            it;

  assign it = stage_i.item;

  // one read address: host index for a get, else the pointer
  assign rd_sel = (it.cmd == CMD_HOST_GET) ? it.host_index : ptr_q;
  assign rd_ok  = ({1'b0, rd_sel} < (PTR_W+1)'(NUM_REGS));
  assign rd_val = rd_ok ? bank_q[rd_sel[IDX_W-1:0]] : 8'h00;

  assign ptr_inc  = {1'b0, ptr_q} + (PTR_W+1)'(1);
  assign ptr_next = (ptr_inc >= (PTR_W+1)'(NUM_REGS)) ? '0 : ptr_inc[PTR_W-1:0];

  assign in_window = (ptr_q >= PTR_W'(RW_FIRST)) && (ptr_q <= PTR_W'(RW_LAST))
                     && ({1'b0, ptr_q} < (PTR_W+1)'(NUM_REGS));

  always_comb begin
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    wr_idx   = ptr_q[IDX_W-1:0];
    wr_val   = it.data;
    result_d = '0;
    case (it.cmd)
      CMD_START, CMD_STOP: begin
        cnt_d = '0;
      end
      CMD_WR_BYTE: begin
        if (cnt_q < CNT_W'(WRITE_BUF_BYTES)) begin
          if (cnt_q == '0) begin
            // first byte loads the pointer
            ptr_d = (it.data >= 8'(NUM_REGS)) ? '0 : it.data[PTR_W-1:0];
          end else begin
            if (in_window && (rd_val != it.data)) begin
              wr_en                  = 1'b1;
              result_d.value_changed = 1'b1;
            end
            ptr_d = ptr_next;
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      CMD_RD_BYTE: begin
        result_d.read_data = rd_val;
        ptr_d              = ptr_next;
      end
      CMD_HOST_SET: begin
        wr_idx = it.host_index[IDX_W-1:0];
        if ((it.host_index > PTR_W'(VERSION_SLOT))
            && ({1'b0, it.host_index} < (PTR_W+1)'(NUM_REGS))) begin
          wr_en = 1'b1;
        end
      end
      CMD_HOST_GET: begin
        result_d.read_data = rd_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        bank_q[i] <= bank_reset_value(i);
      end
    end else begin
      done_q <= stage_i.valid;
      if (stage_i.valid) begin
        ptr_q <= ptr_d;
        cnt_q <= cnt_d;
        if (wr_en) begin
          bank_q[wr_idx] <= wr_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

>>> design/i2c_target_register_map_unit.sv
// Top level of the I2C target register map: capture stage, map core and checks.
// Path: a taken beat is registered in the capture stage and then in the core, whose
//   result register shows its result with done_o high.
// Throughput: one event per cycle; busy_o is tied low and never rises.
// Reset: rst_ni clears the pointer, the write counter and the strobe, and loads the
//   bank with zeros, the board ID in slot 0 and the version in slot 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module i2c_target_register_map_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire i2crm_pkg::item_t item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output i2crm_pkg::result_t    result_o
);
  import i2crm_pkg::*;

  stage_t stage;
  logic   take;

  // The core never stalls, so never hold off the sender.
  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  // Capture the event beat.
  i2crm_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (item_i),
    .stage_o (stage)
  );

  // Update bank, pointer and counter; register the result beat.
  i2crm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Every accepted beat yields a result strobe once it has passed both registers.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> ##1 done_o)
    else $error("accepted beat produced no result strobe");

  // No strobe without a matching accepted beat.
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, 2))
    else $error("result strobe without an accepted beat");

  // Only a bus write byte may flag a change.
  a_changed_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.value_changed) |-> ($past(item_i.cmd, 2) == CMD_WR_BYTE))
    else $error("value_changed set for an event other than a bus write");

  // Read data is zero except for bus reads and host gets.
  a_read_data_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.read_data != 8'h00)) |->
      (($past(item_i.cmd, 2) == CMD_RD_BYTE) || ($past(item_i.cmd, 2) == CMD_HOST_GET)))
    else $error("read data returned for a non-read event");

endmodule

`default_nettype wire
